@@ rtl/core/slir_pkg.sv @@
// ----------------------------------------------------------------------------
// slir_pkg: shared types and constants for the list insert/remove block
// Sizes, op and status codes, register indexes and the stack control word.
// ----------------------------------------------------------------------------
`default_nettype none

package slir_pkg;

    localparam int DEPTH       = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(DEPTH + 1);

    // op codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_DUP      = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_RANGE    = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_SORTED   = 2'd0;
    localparam logic [1:0] CFG_REPEATS  = 2'd1;
    localparam logic [1:0] CFG_CAPACITY = 2'd2;

    typedef struct packed {
        logic push;
        logic pop;
    } stack_ctl_t;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;

endpackage

`default_nettype wire

@@ rtl/core/slir_cell.sv @@
// ----------------------------------------------------------------------------
// slir_cell: one storage cell of a stack chain
// Holds one value; takes the upper neighbor on push, the lower one on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module slir_cell
    import slir_pkg::*;
(
    input  wire logic       aclk,
    input  wire stack_ctl_t ctl,
    input  wire value_t     above,
    input  wire value_t     below,
    output value_t          value
);

    value_t value_reg;
    value_t value_next;

    always_comb begin
        if (ctl.push) begin
            value_next = above;
        end else if (ctl.pop) begin
            value_next = below;
        end else begin
            value_next = value_reg;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

@@ rtl/core/slir_stack.sv @@
// ----------------------------------------------------------------------------
// slir_stack: push/pop stack built as a chain of cells
// Cell 0 is the top; all cells shift together on push or pop.
// ----------------------------------------------------------------------------
`default_nettype none

module slir_stack
    import slir_pkg::*;
(
    input  wire logic       aclk,
    input  wire stack_ctl_t ctl,
    input  wire value_t     push_data,
    output value_t          top_data
);

    value_t cell_val [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        value_t above_w;
        value_t below_w;

        if (i == 0) begin : g_first
            assign above_w = push_data;
        end else begin : g_mid
            assign above_w = cell_val[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign below_w = cell_val[i];
        end else begin : g_inner
            assign below_w = cell_val[i+1];
        end

        slir_cell u_cell (
            .aclk  (aclk),
            .ctl   (ctl),
            .above (above_w),
            .below (below_w),
            .value (cell_val[i])
        );
    end

    assign top_data = cell_val[0];

endmodule

`default_nettype wire

@@ rtl/core/sequential_list_insert_remove.sv @@
// ----------------------------------------------------------------------------
// sequential_list_insert_remove: bounded list with insert, remove and read
// The list is a gap buffer of two cell-chain stacks around a cursor. Moving
// the cursor a step, inserting or deleting at it each shift the stacks once.
//
// Input words on s_*: op, value, index. One result word per input on m_*:
// status, removed count, read value and entry count after the operation.
// Config writes (cfg_wen/cfg_index/cfg_wdata) belong in idle gaps only.
//
// One item at a time. An early reject goes straight to the result; other
// words first move the cursor through the stacks one step at a time:
// a read moves the cursor to the index, a linear search walks from entry 0,
// a binary search seeks mid points, and an insert/delete then seeks the
// position. An unsorted insert with repeats allowed seeks the end. A remove
// with repeats allowed takes every match. The next word can be taken in
// the cycle after the result word is loaded.
//
// Reset (synchronous, active low) empties the list and loads the register
// defaults. A finished result waits in the output register while m_tready
// is low; the block holds in its final state until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module sequential_list_insert_remove
    import slir_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wen,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [6:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // op[1:0], value[33:2], index[39:34]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata    // status[2:0], removed_count[9:3],
                                        // read_value[41:10], entry_count[48:42]
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SEEK  = 4'd1;
    localparam logic [3:0] S_BS    = 4'd2;
    localparam logic [3:0] S_BSCMP = 4'd3;
    localparam logic [3:0] S_LIN   = 4'd4;
    localparam logic [3:0] S_RES   = 4'd5;
    localparam logic [3:0] S_INS   = 4'd6;
    localparam logic [3:0] S_DEL   = 4'd7;
    localparam logic [3:0] S_ALL   = 4'd8;
    localparam logic [3:0] S_RUNL  = 4'd9;
    localparam logic [3:0] S_RUNR  = 4'd10;
    localparam logic [3:0] S_READ  = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    logic [3:0]       state_reg,   state_next;
    logic [3:0]       ret_reg,     ret_next;
    logic [1:0]       op_reg,      op_next;
    value_t           key_reg,     key_next;
    logic [CNT_W-1:0] count_reg,   count_next;
    logic [CNT_W-1:0] cur_reg,     cur_next;
    logic [CNT_W-1:0] tgt_reg,     tgt_next;
    logic [CNT_W-1:0] lo_reg,      lo_next;
    logic [CNT_W-1:0] hip1_reg,    hip1_next;
    logic [CNT_W-1:0] pos_reg,     pos_next;
    logic             hit_reg,     hit_next;
    logic [CNT_W-1:0] rem_reg,     rem_next;
    logic [2:0]       status_reg,  status_next;
    value_t           rd_reg,      rd_next;
    logic             sorted_reg,  sorted_next;
    logic             repeats_reg, repeats_next;
    logic [6:0]       cap_reg,     cap_next;
    logic             m_valid_reg, m_valid_next;
    logic [55:0]      m_data_reg,  m_data_next;

    stack_ctl_t left_ctl, right_ctl;
    value_t     left_din, right_din;
    value_t     left_top, right_top;

    logic [1:0]       in_op;
    value_t           in_key;
    logic [CNT_W-1:0] in_idx;
    logic [CNT_W-1:0] cap_eff;
    logic [CNT_W:0]   mid_sum;
    logic [CNT_W-1:0] mid;
    logic             r_eq, r_gt, l_eq, r_avail;

    slir_stack u_left (
        .aclk      (aclk),
        .ctl       (left_ctl),
        .push_data (left_din),
        .top_data  (left_top)
    );

    slir_stack u_right (
        .aclk      (aclk),
        .ctl       (right_ctl),
        .push_data (right_din),
        .top_data  (right_top)
    );

    assign in_op  = s_tdata[1:0];
    assign in_key = VALUE_WIDTH'(signed'(s_tdata[33:2]));
    assign in_idx = CNT_W'(s_tdata[39:34]);

    always_comb begin
        if (32'(cap_reg) > 32'(DEPTH)) begin
            cap_eff = CNT_W'(DEPTH);
        end else begin
            cap_eff = CNT_W'(cap_reg);
        end
    end

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hip1_reg} - {{CNT_W{1'b0}}, 1'b1};
    assign mid     = mid_sum[CNT_W:1];
    assign r_eq    = (right_top == key_reg);
    assign r_gt    = (right_top > key_reg);
    assign l_eq    = (left_top == key_reg);
    assign r_avail = (cur_reg < count_reg);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        count_next   = count_reg;
        cur_next     = cur_reg;
        tgt_next     = tgt_reg;
        lo_next      = lo_reg;
        hip1_next    = hip1_reg;
        pos_next     = pos_reg;
        hit_next     = hit_reg;
        rem_next     = rem_reg;
        status_next  = status_reg;
        rd_next      = rd_reg;
        sorted_next  = sorted_reg;
        repeats_next = repeats_reg;
        cap_next     = cap_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        left_ctl     = '0;
        right_ctl    = '0;
        left_din     = right_top;
        right_din    = left_top;

        if (cfg_wen) begin
            case (cfg_index)
                CFG_SORTED:   sorted_next  = cfg_wdata[0];
                CFG_REPEATS:  repeats_next = cfg_wdata[0];
                CFG_CAPACITY: cap_next     = cfg_wdata;
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next     = in_op;
                    key_next    = in_key;
                    status_next = ST_OK;
                    rem_next    = '0;
                    rd_next     = '0;
                    hit_next    = 1'b0;
                    lo_next     = '0;
                    hip1_next   = count_reg;
                    case (in_op)
                        OP_INSERT: begin
                            if (count_reg >= cap_eff) begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end else if (!sorted_reg && repeats_reg) begin
                                tgt_next   = count_reg;
                                ret_next   = S_INS;
                                state_next = S_SEEK;
                            end else if (sorted_reg) begin
                                state_next = S_BS;
                            end else begin
                                tgt_next   = '0;
                                ret_next   = S_LIN;
                                state_next = S_SEEK;
                            end
                        end
                        OP_REMOVE: begin
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end else if (sorted_reg) begin
                                state_next = S_BS;
                            end else begin
                                tgt_next   = '0;
                                ret_next   = S_LIN;
                                state_next = S_SEEK;
                            end
                        end
                        OP_READ: begin
                            if (in_idx < count_reg) begin
                                tgt_next   = in_idx;
                                ret_next   = S_READ;
                                state_next = S_SEEK;
                            end else begin
                                status_next = ST_RANGE;
                                state_next  = S_DONE;
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_SEEK: begin
                if (cur_reg == tgt_reg) begin
                    state_next = ret_reg;
                end else if (cur_reg < tgt_reg) begin
                    left_ctl.push = 1'b1;
                    right_ctl.pop = 1'b1;
                    cur_next      = cur_reg + 1'b1;
                end else begin
                    right_ctl.push = 1'b1;
                    left_ctl.pop   = 1'b1;
                    cur_next       = cur_reg - 1'b1;
                end
            end
            S_BS: begin
                if (lo_reg < hip1_reg) begin
                    tgt_next   = mid;
                    ret_next   = S_BSCMP;
                    state_next = S_SEEK;
                end else begin
                    hit_next   = 1'b0;
                    pos_next   = lo_reg;
                    state_next = S_RES;
                end
            end
            S_BSCMP: begin
                if (r_eq) begin
                    hit_next   = 1'b1;
                    pos_next   = cur_reg;
                    state_next = S_RES;
                end else if (r_gt) begin
                    hip1_next  = cur_reg;
                    state_next = S_BS;
                end else begin
                    lo_next    = cur_reg + 1'b1;
                    state_next = S_BS;
                end
            end
            S_LIN: begin
                if (r_avail && !r_eq) begin
                    left_ctl.push = 1'b1;
                    right_ctl.pop = 1'b1;
                    cur_next      = cur_reg + 1'b1;
                end else begin
                    hit_next   = r_avail;
                    pos_next   = cur_reg;
                    state_next = S_RES;
                end
            end
            S_RES: begin
                case (op_reg)
                    OP_INSERT: begin
                        if (hit_reg && !repeats_reg) begin
                            status_next = ST_DUP;
                            state_next  = S_DONE;
                        end else begin
                            tgt_next   = pos_reg;
                            ret_next   = S_INS;
                            state_next = S_SEEK;
                        end
                    end
                    OP_REMOVE: begin
                        if (!hit_reg) begin
                            status_next = ST_NOTFOUND;
                            state_next  = S_DONE;
                        end else if (!repeats_reg) begin
                            tgt_next   = pos_reg;
                            ret_next   = S_DEL;
                            state_next = S_SEEK;
                        end else if (!sorted_reg) begin
                            state_next = S_ALL;
                        end else begin
                            tgt_next   = pos_reg;
                            ret_next   = S_RUNL;
                            state_next = S_SEEK;
                        end
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_INS: begin
                right_ctl.push = 1'b1;
                right_din      = key_reg;
                count_next     = count_reg + 1'b1;
                state_next     = S_DONE;
            end
            S_DEL: begin
                right_ctl.pop = 1'b1;
                count_next    = count_reg - 1'b1;
                rem_next      = CNT_W'(1);
                state_next    = S_DONE;
            end
            S_ALL: begin
                if (!r_avail) begin
                    state_next = S_DONE;
                end else if (r_eq) begin
                    right_ctl.pop = 1'b1;
                    count_next    = count_reg - 1'b1;
                    rem_next      = rem_reg + 1'b1;
                end else begin
                    left_ctl.push = 1'b1;
                    right_ctl.pop = 1'b1;
                    cur_next      = cur_reg + 1'b1;
                end
            end
            S_RUNL: begin
                if (cur_reg != '0 && l_eq) begin
                    right_ctl.push = 1'b1;
                    left_ctl.pop   = 1'b1;
                    cur_next       = cur_reg - 1'b1;
                end else begin
                    state_next = S_RUNR;
                end
            end
            S_RUNR: begin
                if (r_avail && r_eq) begin
                    right_ctl.pop = 1'b1;
                    count_next    = count_reg - 1'b1;
                    rem_next      = rem_reg + 1'b1;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_READ: begin
                rd_next    = right_top;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'b0, 7'(count_reg), 32'(rd_reg), 7'(rem_reg), status_reg};
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            cur_reg     <= '0;
            sorted_reg  <= 1'b0;
            repeats_reg <= 1'b0;
            cap_reg     <= 7'd64;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cur_reg     <= cur_next;
            sorted_reg  <= sorted_next;
            repeats_reg <= repeats_next;
            cap_reg     <= cap_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ret_reg    <= ret_next;
        op_reg     <= op_next;
        key_reg    <= key_next;
        tgt_reg    <= tgt_next;
        lo_reg     <= lo_next;
        hip1_reg   <= hip1_next;
        pos_reg    <= pos_next;
        hit_reg    <= hit_next;
        rem_reg    <= rem_next;
        status_reg <= status_next;
        rd_reg     <= rd_next;
        m_data_reg <= m_data_next;
    end

    // cursor stays inside the list
    a_cursor_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_reg <= count_reg)
        else $error("cursor beyond entry count");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= 32'(DEPTH))
        else $error("entry count beyond depth");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ##1 (count_reg == $past(count_reg) || count_reg == $past(count_reg) + 1'b1
             || count_reg == $past(count_reg) - 1'b1))
        else $error("entry count jumped");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result word loaded outside done state");

    a_idle_no_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !(left_ctl.push || left_ctl.pop
                                    || right_ctl.push || right_ctl.pop))
        else $error("stack moved while idle");

endmodule

`default_nettype wire
